// File: hdl/i2cm_pkg.sv
package i2cm_pkg;

    // Command codes carried by an input item
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Operation codes held in the engine state
    localparam logic [2:0] OP_IDLE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_NACK = 3'd5;

    localparam logic [7:0] ACK_WAIT_LIMIT_RESET = 8'd250;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] phase;
        logic [3:0] bit_count;
        logic [7:0] shift_reg;
        logic [7:0] wait_count;
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       ack_timeout;
    } t_state;

    localparam t_state STATE_RESET = '{
        operation:   OP_IDLE,
        phase:       3'd0,
        bit_count:   4'd0,
        shift_reg:   8'd0,
        wait_count:  8'd0,
        scl:         1'b1,
        sda:         1'b1,
        sda_en:      1'b1,
        rx_byte:     8'd0,
        ack_seen:    1'b0,
        ack_timeout: 1'b0
    };

endpackage

// File: hdl/i2c_master_byte_engine_core.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_command, i_tx_byte, i_ack_reply, i_sda_in
// out       output     o_out_valid / i_out_stall o_scl_level .. o_ack_timeout
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (ack_wait_limit)
//
// One item per cycle while the output does not stall; an item passes through the input
// register, then the result register. The engine state loop closes through the phase
// logic, which sets the rate. Synchronous active-low reset returns the lines to SCL
// high, SDA high driven, and loads ack_wait_limit with 250. A stall at the output
// holds the result register and backs up into the input register.
module i2c_master_byte_engine_core (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_command,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_reply,
    input  logic       i_sda_in,

    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_enable,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_seen,
    output logic       o_ack_timeout,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]       r_ack_wait_limit;

    logic             r_in_valid;
    logic [2:0]       r_command;
    logic [7:0]       r_tx_byte;
    logic             r_ack_reply;
    logic             r_sda_in;

    i2cm_pkg::t_state r_state;
    i2cm_pkg::t_state n_state;
    logic             n_done;

    logic             r_out_valid;
    logic             r_out_busy;
    logic             r_out_done;
    i2cm_pkg::t_state r_out_state;

    logic             advance;
    logic             in_take;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_wait_limit <= i2cm_pkg::ACK_WAIT_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ack_wait_limit <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command   <= i_command;
            r_tx_byte   <= i_tx_byte;
            r_ack_reply <= i_ack_reply;
            r_sda_in    <= i_sda_in;
        end
    end

    i2cm_step u_step (
        .i_state          (r_state),
        .i_command        (r_command),
        .i_tx_byte        (r_tx_byte),
        .i_ack_reply      (r_ack_reply),
        .i_sda_in         (r_sda_in),
        .i_ack_wait_limit (r_ack_wait_limit),
        .o_state          (n_state),
        .o_done           (n_done)
    );

    // engine state advances as the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cm_pkg::STATE_RESET;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_state <= n_state;
            r_out_done  <= n_done;
            r_out_busy  <= (n_state.operation != i2cm_pkg::OP_IDLE);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_level   = r_out_state.scl;
    assign o_sda_level   = r_out_state.sda;
    assign o_sda_enable  = r_out_state.sda_en;
    assign o_busy_res    = r_out_busy;
    assign o_done_res    = r_out_done;
    assign o_rx_byte     = r_out_state.rx_byte;
    assign o_ack_seen    = r_out_state.ack_seen;
    assign o_ack_timeout = r_out_state.ack_timeout;

    // a finishing command leaves the engine idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_done && r_out_busy))
        else $error("done reported while still busy");

    // a write ends either acknowledged or timed out, never both
    a_ack_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.ack_seen && r_state.ack_timeout))
        else $error("ack seen and ack timeout both set");

    // the ACK wait runs only with the line released and SCL high
    a_ack_wait_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.operation == i2cm_pkg::OP_WRITE && r_state.phase == 3'd4)
        |-> (r_state.scl && !r_state.sda_en))
        else $error("ack wait with SDA driven or SCL low");

    // a result leaves only after its item passed the input register
    a_out_follows_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> $past(r_in_valid))
        else $error("result appeared without an item");

endmodule

// File: hdl/i2cm_step.sv
module i2cm_step (
    input  i2cm_pkg::t_state i_state,
    input  logic [2:0]       i_command,
    input  logic [7:0]       i_tx_byte,
    input  logic             i_ack_reply,
    input  logic             i_sda_in,
    input  logic [7:0]       i_ack_wait_limit,
    output i2cm_pkg::t_state o_state,
    output logic             o_done
);

    i2cm_pkg::t_state s;
    logic             done;

    always_comb begin
        s    = i_state;
        done = 1'b0;

        // take a command only while idle
        if (s.operation == i2cm_pkg::OP_IDLE &&
            (i_command == i2cm_pkg::CMD_START || i_command == i2cm_pkg::CMD_STOP ||
             i_command == i2cm_pkg::CMD_WRITE || i_command == i2cm_pkg::CMD_READ)) begin
            s.phase      = 3'd0;
            s.bit_count  = 4'd0;
            s.wait_count = 8'd0;
            priority if (i_command == i2cm_pkg::CMD_START) begin
                s.operation = i2cm_pkg::OP_START;
            end else if (i_command == i2cm_pkg::CMD_STOP) begin
                s.operation = i2cm_pkg::OP_STOP;
            end else if (i_command == i2cm_pkg::CMD_WRITE) begin
                s.operation   = i2cm_pkg::OP_WRITE;
                s.shift_reg   = i_tx_byte;
                s.ack_seen    = 1'b0;
                s.ack_timeout = 1'b0;
            end else begin
                s.operation = i_ack_reply ? i2cm_pkg::OP_READ_ACK : i2cm_pkg::OP_READ_NACK;
                s.shift_reg = 8'd0;
            end
        end

        unique case (s.operation)
            i2cm_pkg::OP_IDLE: begin
            end
            i2cm_pkg::OP_START: begin
                unique case (s.phase)
                    3'd0: begin
                        s.scl = 1'b1; s.sda = 1'b1; s.sda_en = 1'b1;
                        s.phase = 3'd1;
                    end
                    3'd1: begin
                        s.scl = 1'b1; s.sda = 1'b0; s.sda_en = 1'b1;
                        s.phase = 3'd2;
                    end
                    3'd2: begin
                        s.scl = 1'b0; s.sda = 1'b0; s.sda_en = 1'b1;
                        s.operation = i2cm_pkg::OP_IDLE;
                        done = 1'b1;
                    end
                    default: s.operation = i2cm_pkg::OP_IDLE;
                endcase
            end
            i2cm_pkg::OP_STOP: begin
                unique case (s.phase)
                    3'd0: begin
                        s.scl = 1'b0; s.sda = 1'b0; s.sda_en = 1'b1;
                        s.phase = 3'd1;
                    end
                    3'd1: begin
                        s.scl = 1'b1; s.sda = 1'b1; s.sda_en = 1'b1;
                        s.operation = i2cm_pkg::OP_IDLE;
                        done = 1'b1;
                    end
                    default: s.operation = i2cm_pkg::OP_IDLE;
                endcase
            end
            i2cm_pkg::OP_WRITE: begin
                unique case (s.phase)
                    3'd0: begin
                        s.scl = 1'b0; s.sda = s.shift_reg[7]; s.sda_en = 1'b1;
                        s.phase = 3'd1;
                    end
                    3'd1: begin
                        s.scl       = 1'b1;
                        s.shift_reg = {s.shift_reg[6:0], 1'b0};
                        s.bit_count = s.bit_count + 4'd1;
                        s.phase     = s.bit_count[3] ? 3'd2 : 3'd0;
                    end
                    3'd2: begin
                        s.scl = 1'b0; s.sda = 1'b1; s.sda_en = 1'b0;
                        s.phase = 3'd3;
                    end
                    3'd3: begin
                        s.scl        = 1'b1;
                        s.wait_count = 8'd0;
                        s.phase      = 3'd4;
                    end
                    3'd4: begin
                        priority if (!i_sda_in) begin
                            s.scl       = 1'b0;
                            s.ack_seen  = 1'b1;
                            s.operation = i2cm_pkg::OP_IDLE;
                            done        = 1'b1;
                        end else if (s.wait_count >= i_ack_wait_limit) begin
                            // timed out: drop into the second half of a stop
                            s.ack_timeout = 1'b1;
                            s.scl = 1'b0; s.sda = 1'b0; s.sda_en = 1'b1;
                            s.operation = i2cm_pkg::OP_STOP;
                            s.phase     = 3'd1;
                        end else begin
                            s.wait_count = s.wait_count + 8'd1;
                        end
                    end
                    default: s.operation = i2cm_pkg::OP_IDLE;
                endcase
            end
            i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NACK: begin
                unique case (s.phase)
                    3'd0: begin
                        s.scl = 1'b0; s.sda = 1'b1; s.sda_en = 1'b0;
                        s.phase = 3'd1;
                    end
                    3'd1: begin
                        s.scl   = 1'b1;
                        s.phase = 3'd2;
                    end
                    3'd2: begin
                        s.shift_reg = {s.shift_reg[6:0], i_sda_in};
                        s.bit_count = s.bit_count + 4'd1;
                        s.phase     = s.bit_count[3] ? 3'd3 : 3'd0;
                    end
                    3'd3: begin
                        s.scl    = 1'b0;
                        s.sda    = (s.operation == i2cm_pkg::OP_READ_ACK) ? 1'b0 : 1'b1;
                        s.sda_en = 1'b1;
                        s.phase  = 3'd4;
                    end
                    3'd4: begin
                        s.scl   = 1'b1;
                        s.phase = 3'd5;
                    end
                    3'd5: begin
                        s.scl       = 1'b0;
                        s.rx_byte   = s.shift_reg;
                        s.operation = i2cm_pkg::OP_IDLE;
                        done        = 1'b1;
                    end
                    default: s.operation = i2cm_pkg::OP_IDLE;
                endcase
            end
            default: s.operation = i2cm_pkg::OP_IDLE;
        endcase
    end

    assign o_state = s;
    assign o_done  = done;

endmodule
